[hw/rtl/text_console_cursor_control_defines.svh]
// assertion macros shared by the console cursor controller rtl
// no dependencies; the assertions compile out when SYNTH is defined
`ifndef TEXT_CONSOLE_CURSOR_CONTROL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_CONTROL_DEFINES_SVH

`ifndef SYNTH
`define TCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcc: implication check failed");
`define TCC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcc: next-cycle check failed");
`else
`define TCC_ASSERT_IMP(lbl, ante, cons)
`define TCC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/tcc_pkg.sv]
// types, codes, constants and the colour palette of the console cursor controller
// no dependencies
`default_nettype none

package tcc_pkg;

  localparam int MAX_COLUMNS = 256;
  localparam int MAX_ROWS    = 128;
  localparam int QUEUE_DEPTH = 4;

  localparam int COL_W = 9;
  localparam int ROW_W = 8;

  typedef enum logic [1:0] {
    CMD_PUTC       = 2'd0,
    CMD_SET_ROW    = 2'd1,
    CMD_SET_COLOUR = 2'd2,
    CMD_CLEAR      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_GLYPH  = 2'd0,
    OP_FILL   = 2'd1,
    OP_SCROLL = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CLS_GLYPH,
    CLS_NEWLINE,
    CLS_RETURN,
    CLS_BACKSPACE,
    CLS_TAB,
    CLS_SET_ROW,
    CLS_SET_COLOUR,
    CLS_CLEAR
  } cls_t;

  localparam logic [1:0] REG_COLUMNS       = 2'd0;
  localparam logic [1:0] REG_REGION_TOP    = 2'd1;
  localparam logic [1:0] REG_REGION_BOTTOM = 2'd2;

  localparam logic [8:0] COLUMNS_RESET = 9'd80;
  localparam logic [6:0] TOP_RESET     = 7'd0;
  localparam logic [6:0] BOTTOM_RESET  = 7'd24;
  localparam logic [3:0] FG_RESET      = 4'd7;
  localparam logic [3:0] BG_RESET      = 4'd0;

  localparam logic [7:0] CHAR_BS          = 8'd8;
  localparam logic [7:0] CHAR_TAB         = 8'd9;
  localparam logic [7:0] CHAR_NL          = 8'd10;
  localparam logic [7:0] CHAR_CR          = 8'd13;
  localparam logic [7:0] CHAR_FIRST_PRINT = 8'd32;
  localparam logic [7:0] CHAR_LAST_PRINT  = 8'd126;
  localparam logic [6:0] CHAR_SUBST       = 7'h3F;

  typedef struct packed {
    cls_t       cls;
    logic [7:0] data;
  } entry_t;

  typedef struct packed {
    logic [COL_W-1:0] ncol;
    logic [6:0]       top;
    logic [6:0]       bot;
  } geom_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  col;
    logic [6:0]  row;
    logic [6:0]  glyph;
    logic [23:0] fg;
    logic [23:0] bg;
    logic [6:0]  stop;
    logic        last;
  } result_t;

  function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
    logic [23:0] rgb;
    unique case (idx)
      4'd0:  rgb = 24'h000000;
      4'd1:  rgb = 24'h0000AA;
      4'd2:  rgb = 24'h00AA00;
      4'd3:  rgb = 24'h00AAAA;
      4'd4:  rgb = 24'hAA0000;
      4'd5:  rgb = 24'hAA00AA;
      4'd6:  rgb = 24'hAA5500;
      4'd7:  rgb = 24'hAAAAAA;
      4'd8:  rgb = 24'h555555;
      4'd9:  rgb = 24'h5555FF;
      4'd10: rgb = 24'h55FF55;
      4'd11: rgb = 24'h55FFFF;
      4'd12: rgb = 24'hFF5555;
      4'd13: rgb = 24'hFF55FF;
      4'd14: rgb = 24'hFFFF55;
      default: rgb = 24'hFFFFFF;
    endcase
    return rgb;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tcc_front.sv]
// front end: takes input transactions and classifies them into queue entries
// depends on tcc_pkg
`default_nettype none

module tcc_front (
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_command,
  input  logic [7:0]      in_char_code,
  input  logic [7:0]      in_row_request,
  input  logic [7:0]      in_color_attr,
  input  logic            q_full,
  output logic            push,
  output tcc_pkg::entry_t entry
);
  import tcc_pkg::*;

  logic printable;

  assign in_ready  = !q_full;
  assign push      = in_valid && !q_full;
  assign printable = (in_char_code >= CHAR_FIRST_PRINT) && (in_char_code <= CHAR_LAST_PRINT);

  always_comb begin
    entry.cls  = CLS_GLYPH;
    entry.data = in_char_code;
    unique case (cmd_t'(in_command))
      CMD_PUTC: begin
        unique case (in_char_code)
          CHAR_NL:  entry.cls = CLS_NEWLINE;
          CHAR_CR:  entry.cls = CLS_RETURN;
          CHAR_BS:  entry.cls = CLS_BACKSPACE;
          CHAR_TAB: entry.cls = CLS_TAB;
          default: begin
            entry.cls  = CLS_GLYPH;
            entry.data = printable ? in_char_code : {1'b0, CHAR_SUBST};
          end
        endcase
      end
      CMD_SET_ROW: begin
        entry.cls  = CLS_SET_ROW;
        entry.data = in_row_request;
      end
      CMD_SET_COLOUR: begin
        entry.cls  = CLS_SET_COLOUR;
        entry.data = in_color_attr;
      end
      CMD_CLEAR: begin
        entry.cls  = CLS_CLEAR;
        entry.data = in_char_code;
      end
      default: begin
        entry.cls  = CLS_GLYPH;
        entry.data = in_char_code;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/tcc_queue.sv]
// short queue of classified entries between front and back end
// depends on tcc_pkg and the assertion macro header
`default_nettype none
`include "text_console_cursor_control_defines.svh"

module tcc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tcc_pkg::entry_t entry_in,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output tcc_pkg::entry_t entry_out
);
  import tcc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign entry_out = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= entry_in;
    end
  end

  `TCC_ASSERT_IMP(a_q_bounded, 1'b1, count_r <= CNT_W'(QUEUE_DEPTH))
  `TCC_ASSERT_IMP(a_q_pop_nonempty, pop, count_r != '0)
  `TCC_ASSERT_NXT(a_q_push_grows, push && !pop, count_r == $past(count_r) + CNT_W'(1))

endmodule

`default_nettype wire

[hw/rtl/tcc_back.sv]
// back end: cursor and colour state, executes entries and registers result transactions
// depends on tcc_pkg and the assertion macro header
`default_nettype none
`include "text_console_cursor_control_defines.svh"

module tcc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  tcc_pkg::entry_t  q_entry,
  output logic             pop,
  input  tcc_pkg::geom_t   geom,
  output logic             out_valid,
  input  logic             out_ready,
  output tcc_pkg::result_t out_res
);
  import tcc_pkg::*;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [3:0]       fg_r, fg_nxt;
  logic [3:0]       bg_r, bg_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_r, out_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  result_t          pend_r, pend_nxt;

  logic             can_load;
  logic             is_putc;
  logic             a_valid;
  op_t              a_op;
  logic [COL_W-1:0] a_col;
  logic [COL_W-1:0] c1, c2;
  logic [ROW_W-1:0] r1, r2;
  logic             scroll;
  logic             two;
  logic [ROW_W-1:0] row_req;
  logic [23:0]      fg_rgb, bg_rgb;
  result_t          res_a, res_s, res_c, first;

  assign can_load  = !out_valid_r || out_ready;
  assign pop       = q_valid && can_load && !pend_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;
  assign fg_rgb    = palette_rgb(fg_r);
  assign bg_rgb    = palette_rgb(bg_r);

  // execute the entry at the head of the queue
  always_comb begin
    is_putc = 1'b0;
    a_valid = 1'b0;
    a_op    = OP_GLYPH;
    a_col   = col_r;
    c1      = col_r;
    r1      = row_r;
    unique case (q_entry.cls)
      CLS_GLYPH: begin
        is_putc = 1'b1;
        a_valid = 1'b1;
        c1      = col_r + COL_W'(1);
      end
      CLS_NEWLINE: begin
        is_putc = 1'b1;
        c1      = '0;
        r1      = row_r + ROW_W'(1);
      end
      CLS_RETURN: begin
        is_putc = 1'b1;
        c1      = '0;
      end
      CLS_BACKSPACE: begin
        is_putc = 1'b1;
        if (col_r != '0) begin
          a_valid = 1'b1;
          a_op    = OP_FILL;
          c1      = col_r - COL_W'(1);
          a_col   = col_r - COL_W'(1);
        end
      end
      CLS_TAB: begin
        is_putc = 1'b1;
        c1      = {col_r[COL_W-1:3] + (COL_W-3)'(1), 3'b000};
      end
      default: begin
        is_putc = 1'b0;
      end
    endcase

    // wrap past the last column
    if (c1 >= geom.ncol) begin
      c2 = '0;
      r2 = r1 + ROW_W'(1);
    end else begin
      c2 = c1;
      r2 = r1;
    end
    scroll = is_putc && (r2 > {1'b0, geom.bot});
    two    = a_valid && scroll;

    // clamp of a requested row into the region
    row_req = q_entry.data;
    if (row_req < {1'b0, geom.top}) begin
      row_req = {1'b0, geom.top};
    end
    if (row_req > {1'b0, geom.bot}) begin
      row_req = {1'b0, geom.bot};
    end

    res_a.op    = a_op;
    res_a.col   = a_col[7:0];
    res_a.row   = row_r[6:0];
    res_a.glyph = (a_op == OP_GLYPH) ? q_entry.data[6:0] : 7'd0;
    res_a.fg    = fg_rgb;
    res_a.bg    = bg_rgb;
    res_a.stop  = 7'd0;
    res_a.last  = !two;

    res_s.op    = OP_SCROLL;
    res_s.col   = 8'd0;
    res_s.row   = geom.bot;
    res_s.glyph = 7'd0;
    res_s.fg    = fg_rgb;
    res_s.bg    = bg_rgb;
    res_s.stop  = geom.top;
    res_s.last  = 1'b1;

    res_c.op    = OP_CLEAR;
    res_c.col   = 8'd0;
    res_c.row   = 7'd0;
    res_c.glyph = 7'd0;
    res_c.fg    = fg_rgb;
    res_c.bg    = bg_rgb;
    res_c.stop  = 7'd0;
    res_c.last  = 1'b1;

    if (a_valid) begin
      first = res_a;
    end else if (scroll) begin
      first = res_s;
    end else begin
      first = res_c;
    end
  end

  // state update and output staging
  always_comb begin
    col_nxt        = col_r;
    row_nxt        = row_r;
    fg_nxt         = fg_r;
    bg_nxt         = bg_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;

    if (pop) begin
      unique case (q_entry.cls)
        CLS_SET_ROW: begin
          col_nxt = '0;
          row_nxt = row_req;
        end
        CLS_SET_COLOUR: begin
          fg_nxt = q_entry.data[3:0];
          bg_nxt = q_entry.data[7:4];
        end
        CLS_CLEAR: begin
          col_nxt = '0;
          row_nxt = '0;
        end
        default: begin
          col_nxt = c2;
          row_nxt = scroll ? {1'b0, geom.bot} : r2;
        end
      endcase
    end

    if (can_load) begin
      if (pend_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = pend_r;
        pend_valid_nxt = 1'b0;
      end else if (pop && (a_valid || scroll || q_entry.cls == CLS_CLEAR)) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = first;
        pend_valid_nxt = two;
        pend_nxt       = res_s;
      end else begin
        out_valid_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      fg_r         <= FG_RESET;
      bg_r         <= BG_RESET;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      fg_r         <= fg_nxt;
      bg_r         <= bg_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  `TCC_ASSERT_IMP(a_b_pend_behind_out, pend_valid_r, out_valid_r)
  `TCC_ASSERT_IMP(a_b_pend_is_scroll, pend_valid_r, pend_r.last && pend_r.op == OP_SCROLL)
  `TCC_ASSERT_IMP(a_b_scroll_last, out_valid_r && out_r.op == OP_SCROLL, out_r.last)

endmodule

`default_nettype wire

[hw/rtl/text_console_cursor_control.sv]
// flow: an accepted transaction is queued, then executed into the registered output
// throughput: one input transaction per cycle while the queue has room; an input with
//   two results holds the output for both, and the four-entry queue absorbs the difference
// reset: synchronous active low; columns 80, region rows 0 to 24, cursor home,
//   colours light grey on black, queue and output empty; no clearing pass
`default_nettype none

module text_console_cursor_control (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_row_request,
  input  logic [7:0]  in_color_attr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_op,
  output logic [7:0]  out_cell_col,
  output logic [6:0]  out_cell_row,
  output logic [6:0]  out_glyph,
  output logic [23:0] out_fg_rgb,
  output logic [23:0] out_bg_rgb,
  output logic [6:0]  out_scroll_top,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tcc_pkg::*;

  logic [8:0] columns_r;
  logic [6:0] region_top_r;
  logic [6:0] region_bottom_r;
  logic [6:0] top_sat;
  geom_t      geom;
  logic       q_full;
  logic       q_push;
  entry_t     q_in;
  logic       q_pop;
  logic       q_not_empty;
  entry_t     q_out;
  result_t    res;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r       <= COLUMNS_RESET;
      region_top_r    <= TOP_RESET;
      region_bottom_r <= BOTTOM_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_COLUMNS:       columns_r       <= pwdata[8:0];
        REG_REGION_TOP:    region_top_r    <= pwdata[6:0];
        REG_REGION_BOTTOM: region_bottom_r <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_COLUMNS:       prdata = 32'(columns_r);
      REG_REGION_TOP:    prdata = 32'(region_top_r);
      REG_REGION_BOTTOM: prdata = 32'(region_bottom_r);
      default:           prdata = 32'd0;
    endcase
  end

  // effective geometry
  always_comb begin
    if (columns_r == '0) begin
      geom.ncol = COL_W'(1);
    end else if (int'(columns_r) > MAX_COLUMNS) begin
      geom.ncol = COL_W'(MAX_COLUMNS);
    end else begin
      geom.ncol = columns_r;
    end
    geom.bot = (int'(region_bottom_r) > MAX_ROWS - 1) ? 7'(MAX_ROWS - 1) : region_bottom_r;
    top_sat  = (int'(region_top_r) > MAX_ROWS - 1) ? 7'(MAX_ROWS - 1) : region_top_r;
    geom.top = (top_sat > geom.bot) ? geom.bot : top_sat;
  end

  tcc_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_char_code   (in_char_code),
    .in_row_request (in_row_request),
    .in_color_attr  (in_color_attr),
    .q_full         (q_full),
    .push           (q_push),
    .entry          (q_in)
  );

  tcc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .entry_in  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .entry_out (q_out)
  );

  tcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_entry   (q_out),
    .pop       (q_pop),
    .geom      (geom),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_op         = res.op;
  assign out_cell_col   = res.col;
  assign out_cell_row   = res.row;
  assign out_glyph      = res.glyph;
  assign out_fg_rgb     = res.fg;
  assign out_bg_rgb     = res.bg;
  assign out_scroll_top = res.stop;
  assign out_last       = res.last;

endmodule

`default_nettype wire

[sim/text_console_cursor_control_tb.sv]
// testbench for the console cursor controller: directed and random command streams
// checked against a cycle-free prediction of the drawing orders and register readback
// depends on tcc_pkg and text_console_cursor_control
`timescale 1ns / 100ps

module text_console_cursor_control_tb;
  import tcc_pkg::*;

  localparam int IDLE_PCT       = 32;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int REPORT_LIMIT   = 10;
  localparam int PHASE_ITEMS    = 180;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_command;
  logic [7:0]  in_char_code;
  logic [7:0]  in_row_request;
  logic [7:0]  in_color_attr;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_op;
  logic [7:0]  out_cell_col;
  logic [6:0]  out_cell_row;
  logic [6:0]  out_glyph;
  logic [23:0] out_fg_rgb;
  logic [23:0] out_bg_rgb;
  logic [6:0]  out_scroll_top;
  logic        out_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // console state as the block should hold it
  logic [8:0]  model_columns;
  logic [6:0]  model_top;
  logic [6:0]  model_bottom;
  logic [8:0]  cur_col;
  logic [7:0]  cur_row;
  logic [3:0]  fg_idx;
  logic [3:0]  bg_idx;
  logic [23:0] vga_rgb [16];

  result_t pending_draws [$];
  int      error_count   = 0;
  int      idle_cycles   = 0;
  int      hold_requests = 0;
  logic    steady        = 1'b0;

  text_console_cursor_control u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_char_code   (in_char_code),
    .in_row_request (in_row_request),
    .in_color_attr  (in_color_attr),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_op         (out_op),
    .out_cell_col   (out_cell_col),
    .out_cell_row   (out_cell_row),
    .out_glyph      (out_glyph),
    .out_fg_rgb     (out_fg_rgb),
    .out_bg_rgb     (out_bg_rgb),
    .out_scroll_top (out_scroll_top),
    .out_last       (out_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t draw_order(input op_t op, input logic [7:0] col,
                                         input logic [6:0] row, input logic [6:0] glyph,
                                         input logic [6:0] stop);
    result_t r;
    r.op    = op;
    r.col   = col;
    r.row   = row;
    r.glyph = glyph;
    r.fg    = vga_rgb[fg_idx];
    r.bg    = vga_rgb[bg_idx];
    r.stop  = stop;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic void predict_draw_orders(input cmd_t cmd, input logic [7:0] ch,
                                              input logic [7:0] req, input logic [7:0] attr);
    result_t    orders [2];
    int         n;
    int         ncol;
    logic [6:0] top;
    logic [7:0] row_req;
    n    = 0;
    // inverted region collapses onto the bottom row
    top  = (model_top > model_bottom) ? model_bottom : model_top;
    ncol = model_columns;
    if (ncol == 0) ncol = 1;
    if (ncol > MAX_COLUMNS) ncol = MAX_COLUMNS;
    case (cmd)
      CMD_PUTC: begin
        if (ch == CHAR_NL) begin
          cur_col = '0;
          cur_row = cur_row + 8'd1;
        end else if (ch == CHAR_CR) begin
          cur_col = '0;
        end else if (ch == CHAR_BS) begin
          if (cur_col != '0) begin
            cur_col     = cur_col - 9'd1;
            orders[n++] = draw_order(OP_FILL, cur_col[7:0], cur_row[6:0], 7'd0, 7'd0);
          end
        end else if (ch == CHAR_TAB) begin
          cur_col = (cur_col + 9'd8) & ~9'd7;
        end else begin
          orders[n++] = draw_order(OP_GLYPH, cur_col[7:0], cur_row[6:0],
                                   (ch >= CHAR_FIRST_PRINT && ch <= CHAR_LAST_PRINT) ?
                                   ch[6:0] : CHAR_SUBST, 7'd0);
          cur_col = cur_col + 9'd1;
        end
        if (int'(cur_col) >= ncol) begin
          cur_col = '0;
          cur_row = cur_row + 8'd1;
        end
        if (cur_row > {1'b0, model_bottom}) begin
          orders[n++] = draw_order(OP_SCROLL, 8'd0, model_bottom, 7'd0, top);
          cur_row     = {1'b0, model_bottom};
        end
      end
      CMD_SET_ROW: begin
        row_req = req;
        if (row_req < {1'b0, top}) row_req = {1'b0, top};
        if (row_req > {1'b0, model_bottom}) row_req = {1'b0, model_bottom};
        cur_row = row_req;
        cur_col = '0;
      end
      CMD_SET_COLOUR: begin
        fg_idx = attr[3:0];
        bg_idx = attr[7:4];
      end
      default: begin
        orders[n++] = draw_order(OP_CLEAR, 8'd0, 7'd0, 7'd0, 7'd0);
        cur_col     = '0;
        cur_row     = '0;
      end
    endcase
    if (n > 0) orders[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_draws.push_back(orders[i]);
  endfunction

  task automatic send_cmd(input cmd_t cmd, input logic [7:0] ch, input logic [7:0] req,
                          input logic [7:0] attr);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_char_code   <= ch;
    in_row_request <= req;
    in_color_attr  <= attr;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_draw_orders(cmd, ch, req, attr);
  endtask

  task automatic send_random_cmd();
    cmd_t       cmd;
    logic [7:0] ch;
    logic [7:0] req;
    logic [7:0] attr;
    int         roll;
    int         pick;
    ch   = 8'($urandom);
    req  = 8'($urandom);
    attr = 8'($urandom);
    roll = $urandom_range(99);
    if (roll < 72) begin
      cmd  = CMD_PUTC;
      pick = $urandom_range(99);
      if (pick < 8)       ch = CHAR_BS;
      else if (pick < 16) ch = CHAR_TAB;
      else if (pick < 26) ch = CHAR_NL;
      else if (pick < 30) ch = CHAR_CR;
      else if (pick >= 40) ch = 8'($urandom_range(126, 32));
    end else if (roll < 84) begin
      cmd = CMD_SET_ROW;
    end else if (roll < 96) begin
      cmd = CMD_SET_COLOUR;
    end else begin
      cmd = CMD_CLEAR;
    end
    send_cmd(cmd, ch, req, attr);
  endtask

  // drain everything outstanding, including commands that draw nothing
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] mask;
    mask    = (idx == REG_COLUMNS) ? 32'h1FF : 32'h7F;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_COLUMNS:    model_columns = value[8:0];
      REG_REGION_TOP: model_top     = value[6:0];
      default:        model_bottom  = value[6:0];
    endcase
    // read back in the following transaction
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if ((prdata & mask) !== (value & mask)) begin
      error_count++;
      if (error_count <= REPORT_LIMIT)
        $display("%0t readback reg %0d: expected %0h, got %0h", $realtime, idx,
                 value & mask, prdata & mask);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_cmd(CMD_PUTC, 8'd32, 8'($urandom), 8'($urandom));
    send_cmd(CMD_PUTC, 8'd126, 8'($urandom), 8'($urandom));
    send_cmd(CMD_PUTC, 8'd0, 8'($urandom), 8'($urandom));
    send_cmd(CMD_PUTC, 8'd31, 8'($urandom), 8'($urandom));
    send_cmd(CMD_PUTC, 8'd127, 8'($urandom), 8'($urandom));
    send_cmd(CMD_PUTC, 8'd255, 8'($urandom), 8'($urandom));
    send_cmd(CMD_PUTC, CHAR_BS, 8'($urandom), 8'($urandom));
    send_cmd(CMD_PUTC, CHAR_TAB, 8'($urandom), 8'($urandom));
    send_cmd(CMD_PUTC, CHAR_CR, 8'($urandom), 8'($urandom));
    send_cmd(CMD_PUTC, CHAR_BS, 8'($urandom), 8'($urandom));
    send_cmd(CMD_SET_COLOUR, 8'($urandom), 8'($urandom), 8'h1E);
    send_cmd(CMD_PUTC, 8'd65, 8'($urandom), 8'($urandom));
    send_cmd(CMD_SET_COLOUR, 8'($urandom), 8'($urandom), 8'hFF);
    send_cmd(CMD_PUTC, 8'd122, 8'($urandom), 8'($urandom));
    send_cmd(CMD_SET_COLOUR, 8'($urandom), 8'($urandom), 8'h00);
    send_cmd(CMD_SET_ROW, 8'($urandom), 8'd255, 8'($urandom));
    send_cmd(CMD_PUTC, CHAR_NL, 8'($urandom), 8'($urandom));
    send_cmd(CMD_SET_ROW, 8'($urandom), 8'd0, 8'($urandom));
    send_cmd(CMD_SET_COLOUR, 8'($urandom), 8'($urandom), 8'h07);
    send_cmd(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
    send_cmd(CMD_SET_ROW, 8'($urandom), 8'd12, 8'($urandom));
  endtask

  // zero and oversized column counts, single-row, full-height and inverted regions
  task automatic test_register_settings();
    logic [8:0] col_set [8];
    logic [6:0] top_set [8];
    logic [6:0] bot_set [8];
    col_set = '{9'd80, 9'd1, 9'd0, 9'd256, 9'd511, 9'd8, 9'd37, 9'd80};
    top_set = '{7'd0, 7'd0, 7'd5, 7'd0, 7'd127, 7'd20, 7'd3, 7'd0};
    bot_set = '{7'd24, 7'd0, 7'd9, 7'd127, 7'd127, 7'd10, 7'd6, 7'd24};
    for (int p = 0; p < 8; p++) begin
      settle();
      write_register(REG_COLUMNS, {23'd0, col_set[p]});
      write_register(REG_REGION_TOP, {25'd0, top_set[p]});
      write_register(REG_REGION_BOTTOM, {25'd0, bot_set[p]});
      repeat (PHASE_ITEMS) send_random_cmd();
    end
  endtask

  task automatic test_backpressure();
    steady = 1'b1;
    hold_requests++;
    repeat (40) send_cmd(CMD_PUTC, 8'($urandom_range(126, 32)), 8'($urandom), 8'($urandom));
    steady = 1'b0;
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    repeat (200) send_random_cmd();
    steady = 1'b0;
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_command     <= CMD_PUTC;
    in_char_code   <= '0;
    in_row_request <= '0;
    in_color_attr  <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    vga_rgb = '{24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
                24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
                24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
                24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF};
    model_columns = COLUMNS_RESET;
    model_top     = TOP_RESET;
    model_bottom  = BOTTOM_RESET;
    cur_col       = '0;
    cur_row       = '0;
    fg_idx        = FG_RESET;
    bg_idx        = BG_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_settings();
    test_backpressure();
    test_steady_stream();
    settle();
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin : receiver
    int holds_done;
    holds_done = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : check_draws
    result_t seen;
    result_t wanted;
    if (rst_n && out_valid && out_ready) begin
      seen.op    = op_t'(out_op);
      seen.col   = out_cell_col;
      seen.row   = out_cell_row;
      seen.glyph = out_glyph;
      seen.fg    = out_fg_rgb;
      seen.bg    = out_bg_rgb;
      seen.stop  = out_scroll_top;
      seen.last  = out_last;
      if (pending_draws.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("%0t unexpected transaction: op %0d col %0d row %0d", $realtime,
                   out_op, out_cell_col, out_cell_row);
      end else begin
        wanted = pending_draws.pop_front();
        if (seen !== wanted) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("%0t mismatch, expected: op %0d col %0d row %0d glyph %0h", $realtime,
                     wanted.op, wanted.col, wanted.row, wanted.glyph);
            $display("  expected: fg %h bg %h top %0d last %0b", wanted.fg, wanted.bg,
                     wanted.stop, wanted.last);
            $display("  got: op %0d col %0d row %0d glyph %0h", seen.op, seen.col,
                     seen.row, seen.glyph);
            $display("  got: fg %h bg %h top %0d last %0b", seen.fg, seen.bg, seen.stop,
                     seen.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule

[text_console_cursor_control.f]
+incdir+hw/rtl
hw/rtl/tcc_pkg.sv
hw/rtl/tcc_front.sv
hw/rtl/tcc_queue.sv
hw/rtl/tcc_back.sv
hw/rtl/text_console_cursor_control.sv
sim/text_console_cursor_control_tb.sv
